### rtl/core/arp_pkg.sv
// arp_pkg: shared types, codes and rectangle helpers for the atlas packer.
// No dependencies.
package arp_pkg;

    localparam int DIM_W = 17;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_rect;

    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_EXPANDED = 2'd1;
    localparam logic [1:0] ST_NOFIT    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic CFG_INIT_W = 1'b0;
    localparam logic CFG_INIT_H = 1'b1;

    // full shared edge: same row band touching sides, or same column band
    function automatic logic can_join(input t_rect a, input t_rect b);
        logic row;
        logic col;
        row = (a.y == b.y) && (a.h == b.h) &&
              ((a.x + a.w == b.x) || (b.x + b.w == a.x));
        col = (a.x == b.x) && (a.w == b.w) &&
              ((a.y + a.h == b.y) || (b.y + b.h == a.y));
        return row || col;
    endfunction

    function automatic t_rect join_rect(input t_rect a, input t_rect b);
        t_rect r;
        logic [DIM_W-1:0] ra;
        logic [DIM_W-1:0] rb;
        logic [DIM_W-1:0] ta;
        logic [DIM_W-1:0] tb;
        ra = a.x + a.w;
        rb = b.x + b.w;
        ta = a.y + a.h;
        tb = b.y + b.h;
        r.x = (a.x < b.x) ? a.x : b.x;
        r.y = (a.y < b.y) ? a.y : b.y;
        r.w = ((ra > rb) ? ra : rb) - r.x;
        r.h = ((ta > tb) ? ta : tb) - r.y;
        return r;
    endfunction

endpackage

### rtl/core/arp_mem.sv
// arp_mem: free-rectangle store, two banks, one write and one read port.
// Depends on arp_pkg.
module arp_mem import arp_pkg::*; #(
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rect         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_rect         o_rdata
);
    t_rect r_mem [0:(2**AW)-1];
    t_rect r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/arp_scan.sv
// arp_scan: min slack-product fit on the active bank, pipelined one entry per cycle.
// Depends on arp_pkg; reads through the store's read port.
module arp_scan import arp_pkg::*; #(
    parameter int MAX_FREE_RECTS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_go,
    input  logic [$clog2(MAX_FREE_RECTS+1)-1:0]   i_count,
    input  logic [DIM_W-1:0]                      i_req_w,
    input  logic [DIM_W-1:0]                      i_req_h,
    output logic [$clog2(MAX_FREE_RECTS)-1:0]     o_raddr,
    input  t_rect                                 i_rdata,
    output logic                                  o_done,
    output logic                                  o_found,
    output logic [$clog2(MAX_FREE_RECTS)-1:0]     o_idx,
    output t_rect                                 o_rect
);
    localparam int CNT_W = $clog2(MAX_FREE_RECTS+1);
    localparam int IDX_W = $clog2(MAX_FREE_RECTS);

    logic             r_run;
    logic [CNT_W-1:0] r_addr;
    logic             r_v0, r_v1, r_v2;
    logic [IDX_W-1:0] r_i0, r_i1, r_i2;
    logic             r_fit1, r_fit2;
    logic [DIM_W-1:0] r_dw, r_dh;
    logic [2*DIM_W-1:0] r_prod;
    t_rect            r_rect1, r_rect2;
    logic             r_found;
    logic [2*DIM_W-1:0] r_best_score;
    logic [IDX_W-1:0] r_best_idx;
    t_rect            r_best_rect;
    logic             issue;

    assign issue   = r_run && (r_addr < i_count);
    assign o_raddr = r_addr[IDX_W-1:0];
    assign o_done  = r_run && !issue && !r_v0 && !r_v1 && !r_v2;
    assign o_found = r_found;
    assign o_idx   = r_best_idx;
    assign o_rect  = r_best_rect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_addr  <= '0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_v0 <= issue;
            r_i0 <= r_addr[IDX_W-1:0];
            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end
            // stage 1: fit test and slack
            r_v1    <= r_v0;
            r_i1    <= r_i0;
            r_rect1 <= i_rdata;
            r_fit1  <= (i_rdata.w >= i_req_w) && (i_rdata.h >= i_req_h);
            r_dw    <= i_rdata.w - i_req_w;
            r_dh    <= i_rdata.h - i_req_h;
            // stage 2: product of width slack and height slack
            r_v2    <= r_v1;
            r_i2    <= r_i1;
            r_rect2 <= r_rect1;
            r_fit2  <= r_fit1;
            r_prod  <= r_dw * r_dh;
            // stage 3: keep strictly smaller, so ties stay at the lower index
            if (r_v2 && r_fit2 && (!r_found || (r_prod < r_best_score))) begin
                r_found      <= 1'b1;
                r_best_score <= r_prod;
                r_best_idx   <= r_i2;
                r_best_rect  <= r_rect2;
            end
            if (o_done) begin
                r_run <= 1'b0;
            end
            if (i_go) begin
                r_run   <= 1'b1;
                r_addr  <= '0;
                r_found <= 1'b0;
            end
        end
    end
endmodule

### rtl/core/atlas_rect_packer.sv
// atlas_rect_packer: guillotine atlas packer, fit by least product of width and height
// slack, one merge pass per placement. Per word: a fit scan over the N free entries (a
// second scan after an expansion), the placement, then the merge pass, where each table
// entry and leftover is checked against the k entries collected so far; then the finish.
// One word in flight; busy covers it. The one-cycle o_valid strobe cannot be stalled.
// Synchronous active-low reset, and a config write while idle, reload the whole atlas.
module atlas_rect_packer import arp_pkg::*; #(
    parameter int MAX_FREE_RECTS = 64,
    parameter int COORD_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_req_width,
    input  logic [15:0] i_req_height,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_x_offset,
    output logic [15:0] o_y_offset,
    output logic [16:0] o_atlas_width_now,
    output logic [16:0] o_atlas_height_now
);
    localparam int CNT_W = $clog2(MAX_FREE_RECTS+1);
    localparam int IDX_W = $clog2(MAX_FREE_RECTS);
    localparam int AW    = IDX_W + 1;
    localparam logic [DIM_W:0] LIMIT = (DIM_W+1)'(1) << COORD_BITS;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN_GO, S_SCAN, S_EXP_A, S_EXP_B, S_PLACE,
        S_M_SRC, S_M_SRCW, S_M_J, S_M_JW
    } t_state;

    t_state           r_state;
    logic             r_bank;        // bank holding the live table
    logic [CNT_W-1:0] r_count;
    logic [DIM_W-1:0] r_init_w, r_init_h, r_aw, r_ah;
    logic [DIM_W-1:0] r_req_w, r_req_h;
    logic             r_expanded;
    t_rect            r_best;
    logic [IDX_W-1:0] r_best_idx;
    t_rect            r_la, r_lb;    // right and top leftovers
    logic             r_la_v, r_lb_v;
    t_rect            r_e;           // element being merged
    logic [CNT_W-1:0] r_i, r_j, r_n;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    t_rect            mem_wdata, mem_rdata;

    logic             scan_go, scan_done, scan_found;
    logic [IDX_W-1:0] scan_raddr, scan_idx;
    t_rect            scan_rect;

    logic [DIM_W-1:0] cfg_val;
    logic [1:0]       nl;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [15:0] v);
        logic [DIM_W:0] e;
        e = {2'b00, v};
        if (v == 16'd0) return DIM_W'(1);
        if (e > LIMIT) return LIMIT[DIM_W-1:0];
        return e[DIM_W-1:0];
    endfunction

    assign cfg_val = clamp_dim(i_cfg_data);
    assign busy    = (r_state != S_IDLE);
    assign scan_go = (r_state == S_SCAN_GO);
    assign nl      = {1'b0, (r_best.w > r_req_w)} + {1'b0, (r_best.h > r_req_h)};

    arp_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    arp_scan #(.MAX_FREE_RECTS(MAX_FREE_RECTS)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (scan_go),
        .i_count (r_count),
        .i_req_w (r_req_w),
        .i_req_h (r_req_h),
        .o_raddr (scan_raddr),
        .i_rdata (mem_rdata),
        .o_done  (scan_done),
        .o_found (scan_found),
        .o_idx   (scan_idx),
        .o_rect  (scan_rect)
    );

    // store port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_bank, r_count[IDX_W-1:0]};
        mem_wdata = r_e;
        mem_raddr = {r_bank, r_i[IDX_W-1:0]};
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = {r_bank, IDX_W'(0)};
                mem_wdata = '{x: '0, y: '0, w: r_init_w, h: r_init_h};
            end
            S_EXP_A: begin
                mem_we    = 1'b1;
                mem_wdata = '{x: r_aw, y: '0, w: r_aw, h: r_ah};
            end
            S_EXP_B: begin
                mem_we    = 1'b1;
                mem_wdata = '{x: '0, y: r_ah, w: DIM_W'({r_aw, 1'b0}), h: r_ah};
            end
            S_SCAN: mem_raddr = {r_bank, scan_raddr};
            S_M_J: begin
                mem_raddr = {~r_bank, r_j[IDX_W-1:0]};
                mem_we    = (r_j >= r_n);
                mem_waddr = {~r_bank, r_n[IDX_W-1:0]};
            end
            S_M_JW: begin
                mem_we    = can_join(r_e, mem_rdata);
                mem_waddr = {~r_bank, r_j[IDX_W-1:0]};
                mem_wdata = join_rect(r_e, mem_rdata);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_bank   <= 1'b0;
            r_count  <= CNT_W'(1);
            r_init_w <= DIM_W'(1024);
            r_init_h <= DIM_W'(1024);
            r_aw     <= DIM_W'(1024);
            r_ah     <= DIM_W'(1024);
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_aw    <= r_init_w;
                    r_ah    <= r_init_h;
                    r_count <= CNT_W'(1);
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_req_w    <= {1'b0, i_req_width};
                        r_req_h    <= {1'b0, i_req_height};
                        r_expanded <= 1'b0;
                        if (i_req_width == 16'd0 || i_req_height == 16'd0) begin
                            o_valid    <= 1'b1;
                            o_status   <= ST_NOFIT;
                            o_x_offset <= '0;
                            o_y_offset <= '0;
                            o_atlas_width_now  <= r_aw;
                            o_atlas_height_now <= r_ah;
                        end else begin
                            r_state <= S_SCAN_GO;
                        end
                    end
                end
                S_SCAN_GO: r_state <= S_SCAN;
                S_SCAN: begin
                    if (scan_done) begin
                        r_best     <= scan_rect;
                        r_best_idx <= scan_idx;
                        if (scan_found) begin
                            r_state <= S_PLACE;
                        end else if (r_expanded ||
                                     ({r_aw, 1'b0} > {1'b0, LIMIT}) ||
                                     ({r_ah, 1'b0} > {1'b0, LIMIT})) begin
                            o_valid    <= 1'b1;
                            o_status   <= ST_NOFIT;
                            o_x_offset <= '0;
                            o_y_offset <= '0;
                            o_atlas_width_now  <= r_aw;
                            o_atlas_height_now <= r_ah;
                            r_state    <= S_IDLE;
                        end else if (({1'b0, r_count} + (CNT_W+1)'(2)) >
                                     (CNT_W+1)'(MAX_FREE_RECTS)) begin
                            o_valid    <= 1'b1;
                            o_status   <= ST_FULL;
                            o_x_offset <= '0;
                            o_y_offset <= '0;
                            o_atlas_width_now  <= r_aw;
                            o_atlas_height_now <= r_ah;
                            r_state    <= S_IDLE;
                        end else begin
                            r_state <= S_EXP_A;
                        end
                    end
                end
                S_EXP_A: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_EXP_B;
                end
                S_EXP_B: begin
                    r_count    <= r_count + 1'b1;
                    r_aw       <= DIM_W'({r_aw, 1'b0});
                    r_ah       <= DIM_W'({r_ah, 1'b0});
                    r_expanded <= 1'b1;
                    r_state    <= S_SCAN_GO;
                end
                S_PLACE: begin
                    if (({1'b0, r_count} + (CNT_W+1)'(nl)) >
                        (CNT_W+1)'(MAX_FREE_RECTS + 1)) begin
                        o_valid    <= 1'b1;
                        o_status   <= ST_FULL;
                        o_x_offset <= '0;
                        o_y_offset <= '0;
                        o_atlas_width_now  <= r_aw;
                        o_atlas_height_now <= r_ah;
                        r_state    <= S_IDLE;
                    end else begin
                        r_la   <= '{x: r_best.x + r_req_w, y: r_best.y,
                                    w: r_best.w - r_req_w, h: r_req_h};
                        r_lb   <= '{x: r_best.x, y: r_best.y + r_req_h,
                                    w: r_best.w, h: r_best.h - r_req_h};
                        r_la_v <= (r_best.w > r_req_w);
                        r_lb_v <= (r_best.h > r_req_h);
                        r_i    <= '0;
                        r_n    <= '0;
                        r_state <= S_M_SRC;
                    end
                end
                // merge: live table minus the winner, then leftovers, into the other bank
                S_M_SRC: begin
                    r_j <= '0;
                    if (r_i < r_count) begin
                        if (r_i[IDX_W-1:0] == r_best_idx) begin
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_state <= S_M_SRCW;
                        end
                    end else if (r_la_v) begin
                        r_la_v  <= 1'b0;
                        r_e     <= r_la;
                        r_state <= S_M_J;
                    end else if (r_lb_v) begin
                        r_lb_v  <= 1'b0;
                        r_e     <= r_lb;
                        r_state <= S_M_J;
                    end else begin
                        r_bank     <= ~r_bank;
                        r_count    <= r_n;
                        o_valid    <= 1'b1;
                        o_status   <= r_expanded ? ST_EXPANDED : ST_PLACED;
                        o_x_offset <= r_best.x[15:0];
                        o_y_offset <= r_best.y[15:0];
                        o_atlas_width_now  <= r_aw;
                        o_atlas_height_now <= r_ah;
                        r_state    <= S_IDLE;
                    end
                end
                S_M_SRCW: begin
                    r_e     <= mem_rdata;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_M_J;
                end
                S_M_J: begin
                    if (r_j >= r_n) begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_M_SRC;
                    end else begin
                        r_state <= S_M_JW;
                    end
                end
                S_M_JW: begin
                    if (can_join(r_e, mem_rdata)) begin
                        r_state <= S_M_SRC;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_M_J;
                    end
                end
                default: r_state <= S_INIT;
            endcase
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_INIT_W) begin
                    r_init_w <= cfg_val;
                end else begin
                    r_init_h <= cfg_val;
                end
                if (r_state == S_IDLE || r_state == S_INIT) begin
                    r_state <= S_INIT;
                end
            end
        end
    end
endmodule

### tb/sv/atlas_rect_packer_tb.sv
// atlas_rect_packer_tb: self-checking bench for the guillotine atlas packer.
// Depends on arp_pkg (rect type, status and register codes) and atlas_rect_packer.
`timescale 1ns / 100ps

module atlas_rect_packer_tb import arp_pkg::*;;

    localparam int SLOTS   = 64;
    localparam int LIMIT   = 65536;
    localparam int N_ITEMS = 1700;

    // one placement answer as the block reports it
    typedef struct {
        logic [1:0]  status;
        logic [15:0] xo;
        logic [15:0] yo;
        logic [16:0] aw;
        logic [16:0] ah;
    } t_place;

    // Shadow free-rect table; predicts each placement answer and holds the
    // answers still owed by the block.
    class placement_board;
        t_rect       slot[SLOTS];
        t_rect       tmp[SLOTS];
        int unsigned used;
        int unsigned cur_w;
        int unsigned cur_h;
        int unsigned base_w;
        int unsigned base_h;
        t_place      owed[$];
        int          errors;

        function new();
            base_w = 1024;
            base_h = 1024;
            errors = 0;
            reload();
        endfunction

        function void reload();
            cur_w   = base_w;
            cur_h   = base_h;
            slot[0] = '{x: '0, y: '0, w: DIM_W'(cur_w), h: DIM_W'(cur_h)};
            used    = 1;
        endfunction

        function void set_reg(logic idx, logic [15:0] v);
            int unsigned d;
            d = (v == 0) ? 1 : v;
            if (idx == CFG_INIT_W) base_w = d;
            else base_h = d;
            reload();
        endfunction

        function int best_fit(int unsigned w, int unsigned h);
            int                best;
            longint unsigned   s;
            longint unsigned   best_s;
            best   = -1;
            best_s = 0;
            for (int i = 0; i < used; i++) begin
                if (slot[i].w >= w && slot[i].h >= h) begin
                    s = longint'(slot[i].w - w) * longint'(slot[i].h - h);
                    if (best < 0 || s < best_s) begin
                        best   = i;
                        best_s = s;
                    end
                end
            end
            return best;
        endfunction

        function bit joinable(t_rect a, t_rect b);
            int unsigned ax;
            int unsigned bx;
            int unsigned ay;
            int unsigned by;
            ax = a.x + a.w;
            bx = b.x + b.w;
            ay = a.y + a.h;
            by = b.y + b.h;
            if (a.y == b.y && a.h == b.h && (ax == b.x || bx == a.x)) return 1;
            if (a.x == b.x && a.w == b.w && (ay == b.y || by == a.y)) return 1;
            return 0;
        endfunction

        function t_rect bound(t_rect a, t_rect b);
            t_rect       r;
            int unsigned ra;
            int unsigned rb;
            int unsigned ta;
            int unsigned tb;
            ra  = a.x + a.w;
            rb  = b.x + b.w;
            ta  = a.y + a.h;
            tb  = b.y + b.h;
            r.x = (a.x < b.x) ? a.x : b.x;
            r.y = (a.y < b.y) ? a.y : b.y;
            r.w = DIM_W'(((ra > rb) ? ra : rb) - r.x);
            r.h = DIM_W'(((ta > tb) ? ta : tb) - r.y);
            return r;
        endfunction

        // single in-order pass: each entry joins the first compatible one kept
        function void coalesce();
            int unsigned n;
            bit          done;
            n = 0;
            for (int i = 0; i < used; i++) begin
                done = 0;
                for (int j = 0; j < n; j++) begin
                    if (!done && joinable(slot[i], tmp[j])) begin
                        tmp[j] = bound(slot[i], tmp[j]);
                        done   = 1;
                    end
                end
                if (!done) begin
                    tmp[n] = slot[i];
                    n++;
                end
            end
            for (int i = 0; i < n; i++) slot[i] = tmp[i];
            used = n;
        endfunction

        function void note_request(logic [15:0] rw, logic [15:0] rh);
            t_place      p;
            int          idx;
            bit          grown;
            bit          stopped;
            int unsigned nl;
            int unsigned w;
            int unsigned h;
            t_rect       r;
            w        = rw;
            h        = rh;
            p.status = ST_NOFIT;
            p.xo     = 0;
            p.yo     = 0;
            if (w != 0 && h != 0) begin
                grown   = 0;
                stopped = 0;
                idx     = best_fit(w, h);
                if (idx < 0) begin
                    if (2 * cur_w > LIMIT || 2 * cur_h > LIMIT) begin
                        stopped = 1;
                    end else if (used + 2 > SLOTS) begin
                        stopped  = 1;
                        p.status = ST_FULL;
                    end else begin
                        // right strip, then top strip over the doubled width
                        slot[used]     = '{x: DIM_W'(cur_w), y: '0,
                                           w: DIM_W'(cur_w), h: DIM_W'(cur_h)};
                        slot[used + 1] = '{x: '0, y: DIM_W'(cur_h),
                                           w: DIM_W'(2 * cur_w), h: DIM_W'(cur_h)};
                        used += 2;
                        cur_w = 2 * cur_w;
                        cur_h = 2 * cur_h;
                        grown = 1;
                        idx   = best_fit(w, h);
                    end
                end
                if (!stopped && idx >= 0) begin
                    r  = slot[idx];
                    nl = (r.w > w) + (r.h > h);
                    if (used - 1 + nl > SLOTS) begin
                        p.status = ST_FULL;
                    end else begin
                        for (int k = idx; k + 1 < used; k++) slot[k] = slot[k + 1];
                        used--;
                        if (r.w > w) begin
                            slot[used] = '{x: DIM_W'(r.x + w), y: r.y,
                                           w: DIM_W'(r.w - w), h: DIM_W'(h)};
                            used++;
                        end
                        if (r.h > h) begin
                            slot[used] = '{x: r.x, y: DIM_W'(r.y + h),
                                           w: r.w, h: DIM_W'(r.h - h)};
                            used++;
                        end
                        coalesce();
                        p.xo     = r.x[15:0];
                        p.yo     = r.y[15:0];
                        p.status = grown ? ST_EXPANDED : ST_PLACED;
                    end
                end
            end
            p.aw = cur_w[16:0];
            p.ah = cur_h[16:0];
            owed = {owed, p};
        endfunction

        function void check_answer(t_place got);
            t_place e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected word status=%0d x=%0d y=%0d", $time,
                         got.status, got.xo, got.yo);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.xo !== e.xo) begin
                $display("%0t: x_offset exp %0d got %0d", $time, e.xo, got.xo);
                errors++;
            end
            if (got.yo !== e.yo) begin
                $display("%0t: y_offset exp %0d got %0d", $time, e.yo, got.yo);
                errors++;
            end
            if (got.aw !== e.aw) begin
                $display("%0t: atlas_width exp %0d got %0d", $time, e.aw, got.aw);
                errors++;
            end
            if (got.ah !== e.ah) begin
                $display("%0t: atlas_height exp %0d got %0d", $time, e.ah, got.ah);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_req_width;
    logic [15:0] i_req_height;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_x_offset;
    logic [15:0] o_y_offset;
    logic [16:0] o_atlas_width_now;
    logic [16:0] o_atlas_height_now;

    placement_board board;
    int             gap_pct;   // chance of an idle gap before each request word

    atlas_rect_packer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_width        (i_req_width),
        .i_req_height       (i_req_height),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_x_offset         (o_x_offset),
        .o_y_offset         (o_y_offset),
        .o_atlas_width_now  (o_atlas_width_now),
        .o_atlas_height_now (o_atlas_height_now)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result words last one cycle; take them at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_answer('{o_status, o_x_offset, o_y_offset,
                                 o_atlas_width_now, o_atlas_height_now});
    end

    // hard stop; worst case is a long merge pass on a full table for every word
    initial begin
        #400_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // one request word; inputs move on the falling edge only
    task automatic send_req(input logic [15:0] w, input logic [15:0] h);
        int gap;
        if ($urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_req_width  = w;
        i_req_height = h;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_request(w, h);
    endtask

    // block is idle only once every owed answer is back and busy has dropped
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (board.owed.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = v;
        board.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // mostly small rectangles against the current atlas, some full-range noise
    task automatic random_reqs(input int n);
        int unsigned sw;
        int unsigned sh;
        int unsigned k;
        logic [15:0] w;
        logic [15:0] h;
        for (int i = 0; i < n; i++) begin
            sw = (board.cur_w > 65535) ? 65535 : board.cur_w;
            sh = (board.cur_h > 65535) ? 65535 : board.cur_h;
            k  = $urandom_range(99);
            if (k < 60) begin
                w = 16'($urandom_range(1, sw / 8 + 1));
                h = 16'($urandom_range(1, sh / 8 + 1));
            end else if (k < 85) begin
                w = 16'($urandom_range(1, sw));
                h = 16'($urandom_range(1, sh));
            end else if (k < 95) begin
                w = 16'($urandom_range(1, 2 * sw < 65535 ? 2 * sw : 65535));
                h = 16'($urandom_range(1, 2 * sh < 65535 ? 2 * sh : 65535));
            end else if (k < 98) begin
                w = 16'($urandom);
                h = 16'($urandom);
            end else begin
                // zero dimension is refused
                w = $urandom_range(1) ? 16'd0 : 16'($urandom);
                h = (w == 0) ? 16'($urandom) : 16'd0;
            end
            send_req(w, h);
        end
    endtask

    initial begin
        board        = new();
        gap_pct      = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_width  = 16'd0;
        i_req_height = 16'd0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = CFG_INIT_W;
        i_cfg_data   = 16'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: default 1024 atlas, exact fit, growth, limits, zero sizes
        send_req(16'd1024, 16'd1024);
        send_req(16'd1, 16'd1);
        send_req(16'd1024, 16'd1024);
        send_req(16'd0, 16'd5);
        send_req(16'd5, 16'd0);
        send_req(16'd0, 16'd0);
        send_req(16'd65535, 16'd65535);
        send_req(16'd32768, 16'd1);
        send_req(16'd1, 16'd32768);
        send_req(16'd100, 16'd3000);
        drain();
        // zero clamps to one texel
        write_reg(CFG_INIT_W, 16'd0);
        write_reg(CFG_INIT_H, 16'd1);
        send_req(16'd1, 16'd1);
        send_req(16'd2, 16'd2);
        send_req(16'd1, 16'd1);
        send_req(16'd4, 16'd1);
        drain();
        // a 32768 atlas can still grow once, to the 65536 limit
        write_reg(CFG_INIT_W, 16'd32768);
        write_reg(CFG_INIT_H, 16'd32768);
        send_req(16'd32768, 16'd32768);
        send_req(16'd1, 16'd1);
        send_req(16'd32768, 16'd16384);
        drain();
        write_reg(CFG_INIT_W, 16'd65535);
        write_reg(CFG_INIT_H, 16'd3);
        send_req(16'd65535, 16'd3);
        send_req(16'd1, 16'd4);
        drain();

        // random: tiny atlases that grow, mid sizes, and the reset size
        gap_pct = 11;
        write_reg(CFG_INIT_W, 16'd16);
        write_reg(CFG_INIT_H, 16'd8);
        random_reqs(300);
        drain();
        write_reg(CFG_INIT_W, 16'($urandom_range(1, 200)));
        write_reg(CFG_INIT_H, 16'($urandom_range(1, 200)));
        random_reqs(300);
        drain();
        gap_pct = 50;
        write_reg(CFG_INIT_W, 16'd1024);
        write_reg(CFG_INIT_H, 16'd1024);
        random_reqs(300);
        drain();
        write_reg(CFG_INIT_W, 16'd1);
        write_reg(CFG_INIT_H, 16'd32768);
        random_reqs(200);
        drain();
        gap_pct = 0;
        write_reg(CFG_INIT_W, 16'($urandom));
        write_reg(CFG_INIT_H, 16'($urandom_range(1, 64)));
        random_reqs(250);
        drain();
        write_reg(CFG_INIT_W, 16'd64);
        write_reg(CFG_INIT_H, 16'd64);
        random_reqs(330);
        drain();

        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### atlas_rect_packer.f
rtl/core/arp_pkg.sv
rtl/core/arp_mem.sv
rtl/core/arp_scan.sv
rtl/core/atlas_rect_packer.sv
tb/sv/atlas_rect_packer_tb.sv
